@@ hw/rtl/sfr_pkg.sv @@
// Shared types and constants for the STX/ETX frame receiver with XOR LRC.
`timescale 1ns / 1ps

package sfr_pkg;

    // Framing bytes
    localparam logic [7:0] STX_CODE = 8'h02;
    localparam logic [7:0] ETX_CODE = 8'h03;

    // Frame layout: STX at 0, stamp 1..8, value 9..12, LRC 13, ETX 14
    localparam int unsigned FRAME_LEN  = 15;
    localparam int unsigned LRC_OFFSET = 13;
    localparam int unsigned STAMP_LAST = 8;
    localparam int unsigned POS_W      = 4;

    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0] POS_STAMP = POS_W'(STAMP_LAST);
    localparam logic [POS_W-1:0] POS_LRC   = POS_W'(LRC_OFFSET);
    localparam logic [POS_W-1:0] POS_ETX   = POS_W'(FRAME_LEN - 1);

    // Configuration register indexes
    localparam logic REG_ENABLE = 1'b0;

    // Result status codes
    typedef enum logic [1:0] {
        ST_GOOD   = 2'd0,
        ST_LENGTH = 2'd1,
        ST_LRC    = 2'd2
    } status_t;

    // One result of the frame parser
    typedef struct packed {
        status_t     status;
        logic [63:0] stamp;
        logic [31:0] value_bits;
        logic [7:0]  lrc_computed;
        logic [7:0]  lrc_received;
    } sfr_result_t;

endpackage

@@ hw/rtl/sfr_parser.sv @@
// Frame parser: STX hunt, field collection, LRC check and ETX check.
`timescale 1ns / 1ps

module sfr_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enable,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    output logic                has_result,
    output sfr_pkg::sfr_result_t result
);
    import sfr_pkg::*;

    typedef enum logic [1:0] {
        HUNT    = 2'b01,
        COLLECT = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]         lrc_accum_reg, lrc_accum_next;
    logic [63:0]        stamp_reg, stamp_next;
    logic [31:0]        value_reg, value_next;
    logic [7:0]         lrc_byte_reg, lrc_byte_next;

    logic is_stx;
    logic is_etx;
    logic at_last;

    assign is_stx  = (rx_byte == STX_CODE);
    assign is_etx  = (rx_byte == ETX_CODE);
    assign at_last = (pos_reg >= POS_ETX);

    // Result decode for the byte at hand
    always_comb
    begin
        has_result = 1'b0;
        result     = '{status: ST_LENGTH, stamp: '0, value_bits: '0,
                       lrc_computed: '0, lrc_received: '0};
        if (enable && state_reg == COLLECT)
        begin
            if (at_last && is_etx)
            begin
                has_result          = 1'b1;
                result.status       = (lrc_accum_reg == lrc_byte_reg) ? ST_GOOD : ST_LRC;
                result.stamp        = stamp_reg;
                result.value_bits   = value_reg;
                result.lrc_computed = lrc_accum_reg;
                result.lrc_received = lrc_byte_reg;
            end
            else if (at_last || is_etx)
            begin
                has_result = 1'b1;
            end
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        lrc_accum_next = lrc_accum_reg;
        stamp_next     = stamp_reg;
        value_next     = value_reg;
        lrc_byte_next  = lrc_byte_reg;
        if (step && enable)
        begin
            unique case (state_reg)
                HUNT:
                begin
                    if (is_stx)
                    begin
                        state_next     = COLLECT;
                        pos_next       = POS_FIRST;
                        lrc_accum_next = '0;
                        stamp_next     = '0;
                        value_next     = '0;
                        lrc_byte_next  = '0;
                    end
                end
                COLLECT:
                begin
                    if (at_last || is_etx)
                    begin
                        state_next = HUNT;
                        pos_next   = '0;
                    end
                    else
                    begin
                        // Stamp bytes, then value bytes, then the LRC byte
                        if (pos_reg <= POS_STAMP)
                        begin
                            stamp_next     = {stamp_reg[55:0], rx_byte};
                            lrc_accum_next = lrc_accum_reg ^ rx_byte;
                        end
                        else if (pos_reg < POS_LRC)
                        begin
                            value_next     = {value_reg[23:0], rx_byte};
                            lrc_accum_next = lrc_accum_reg ^ rx_byte;
                        end
                        else
                        begin
                            lrc_byte_next = rx_byte;
                        end
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                default:
                begin
                    state_next = HUNT;
                    pos_next   = '0;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= HUNT;
            pos_reg       <= '0;
            lrc_accum_reg <= '0;
            stamp_reg     <= '0;
            value_reg     <= '0;
            lrc_byte_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            lrc_accum_reg <= lrc_accum_next;
            stamp_reg     <= stamp_next;
            value_reg     <= value_next;
            lrc_byte_reg  <= lrc_byte_next;
        end
    end

endmodule

@@ hw/rtl/stx_etx_frame_receiver_lrc.sv @@
// Top level: STX/ETX frame receiver with XOR LRC check and APB enable register.
// Path: a byte accepted into the input register is parsed from there; its result,
//   if any, is loaded into the output register (two register stages).
// Throughput: one byte per cycle; the input stage stalls only while a result
//   waits in the output register and the next byte would give another one.
// Reset: rst_n clears enable, the frame state (hunting) and both valid flags.
`timescale 1ns / 1ps

module stx_etx_frame_receiver_lrc (
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Byte input
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            rx_byte,
    // Result output
    output logic                  out_valid,
    input  logic                  out_ready,
    output sfr_pkg::status_t      status,
    output logic [63:0]           stamp,
    output logic [31:0]           value_bits,
    output logic [7:0]            lrc_computed,
    output logic [7:0]            lrc_received
);
    import sfr_pkg::*;

    logic        enable_reg, enable_next;
    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        out_valid_reg, out_valid_next;
    sfr_result_t out_result_reg;

    logic        cfg_write;
    logic        s1_fire;
    logic        has_result;
    sfr_result_t result;

    // APB register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_ENABLE) ? {31'b0, enable_reg} : 32'b0;

    always_comb
    begin
        enable_next = enable_reg;
        if (cfg_write && paddr[2] == REG_ENABLE)
        begin
            enable_next = pwdata[0];
        end
    end

    // Frame parser
    sfr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (enable_reg),
        .step       (s1_fire),
        .rx_byte    (s1_byte_reg),
        .has_result (has_result),
        .result     (result)
    );

    // Stage advance: the held byte moves on unless its result has no room
    assign s1_fire  = s1_valid_reg && (!has_result || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            enable_reg    <= enable_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (s1_fire && has_result)
        begin
            out_result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_result_reg.status;
    assign stamp        = out_result_reg.stamp;
    assign value_bits   = out_result_reg.value_bits;
    assign lrc_computed = out_result_reg.lrc_computed;
    assign lrc_received = out_result_reg.lrc_received;

    // Checks
    a_length_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_LENGTH |->
            stamp == 64'b0 && value_bits == 32'b0 &&
            lrc_computed == 8'b0 && lrc_received == 8'b0)
        else $error("length error result carries nonzero fields");

    a_good_lrc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_GOOD |-> lrc_computed == lrc_received)
        else $error("good frame with mismatched LRC");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_GOOD || status == ST_LENGTH || status == ST_LRC)
        else $error("undefined status code on output");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && has_result && out_valid_reg && !out_ready)
        else $error("input stalled without a blocked result");

endmodule
